>>> design/crs_pkg.sv
// Shared types, sizes and codes for the clip rectangle stack.
package crs_pkg;

  // Stack sizing
  localparam int STACK_DEPTH = 64;
  localparam int LVL_W       = $clog2(STACK_DEPTH);
  localparam int LEVEL_W     = 6;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  // One rectangle edge and a whole rectangle (x1, y1, x2, y2 at index 0..3)
  typedef logic signed [15:0] coord_t;
  typedef coord_t [3:0] rect_t;

  localparam int EDGE_X1 = 0;
  localparam int EDGE_Y1 = 1;
  localparam int EDGE_X2 = 2;
  localparam int EDGE_Y2 = 3;

  // Root rectangle after reset
  localparam coord_t RST_X1 = 16'sd0;
  localparam coord_t RST_Y1 = 16'sd0;
  localparam coord_t RST_X2 = 16'sd1023;
  localparam coord_t RST_Y2 = 16'sd767;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_X1 = 2'd0,
    REG_Y1 = 2'd1,
    REG_X2 = 2'd2,
    REG_Y2 = 2'd3
  } reg_idx_t;

  // Commands
  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_ROOT = 2'd2
  } cmd_t;

  // Result status
  typedef enum logic [1:0] {
    STS_DONE  = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_t;

endpackage

>>> design/clip_rectangle_stack.sv
// Top level of the clip rectangle stack: sequencer, stack memory, config port.
//
//  channel  | handshake                         | payload
//  ---------+-----------------------------------+-----------------------------------------
//  command  | start / busy                      | in_cmd, in_rect_x1/y1/x2/y2
//  result   | out_valid (one-cycle strobe)      | out_cur_x1/y1/x2/y2, out_level, out_status
//  config   | psel, penable, pwrite, pready     | paddr, pwdata, prdata
//
// A push passes the accept cycle, then one edge a cycle through the
// single min/max unit; the stack entry is written with the last edge.
// A pop to a saved level goes through S_LOAD (registered read of the stack memory);
// pop to root, reset to root, ignored commands and cmd 3 finish without leaving idle.
// Synchronous reset returns to level 0 and the reset screen range; the stack
// memory is not cleared (entries are read only after being written).
// The result strobe cannot be stalled; busy holds off new commands.
module clip_rectangle_stack (
  input  logic                         clk,
  input  logic                         rst_n,
  // command channel
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_cmd,
  input  crs_pkg::coord_t              in_rect_x1,
  input  crs_pkg::coord_t              in_rect_y1,
  input  crs_pkg::coord_t              in_rect_x2,
  input  crs_pkg::coord_t              in_rect_y2,
  // result channel
  output logic                         out_valid,
  output crs_pkg::coord_t              out_cur_x1,
  output crs_pkg::coord_t              out_cur_y1,
  output crs_pkg::coord_t              out_cur_x2,
  output crs_pkg::coord_t              out_cur_y2,
  output logic [crs_pkg::LEVEL_W-1:0]  out_level,
  output logic [1:0]                   out_status,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [crs_pkg::ADDR_W-1:0]   paddr,
  input  logic [crs_pkg::DATA_W-1:0]   pwdata,
  output logic [crs_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import crs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLIP,
    S_LOAD
  } state_t;

  localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(STACK_DEPTH - 1);
  localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1);

  state_t           state_r;
  logic [1:0]       edge_idx_r;
  logic [LVL_W-1:0] level_r;
  rect_t            cur_r;
  rect_t            new_r;
  logic             out_valid_r;
  status_t          status_r;
  coord_t           scr_x1_r, scr_y1_r, scr_x2_r, scr_y2_r;

  rect_t            mem [STACK_DEPTH];
  rect_t            rd_data_r;
  rect_t            root_rect;
  rect_t            wr_data;
  logic             wr_en;
  logic [LVL_W-1:0] wr_addr;
  logic [LVL_W-1:0] rd_addr;
  logic             accept;
  logic             cfg_wr;
  coord_t           clip_edge;

  assign accept    = start && !busy;
  assign root_rect = {scr_y2_r, scr_x2_r, scr_y1_r, scr_x1_r};

  // Configuration registers
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_x1_r <= RST_X1;
      scr_y1_r <= RST_Y1;
      scr_x2_r <= RST_X2;
      scr_y2_r <= RST_Y2;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_X1:  scr_x1_r <= pwdata[15:0];
        REG_Y1:  scr_y1_r <= pwdata[15:0];
        REG_X2:  scr_x2_r <= pwdata[15:0];
        REG_Y2:  scr_y2_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_X1:  prdata = DATA_W'(scr_x1_r);
      REG_Y1:  prdata = DATA_W'(scr_y1_r);
      REG_X2:  prdata = DATA_W'(scr_x2_r);
      REG_Y2:  prdata = DATA_W'(scr_y2_r);
      default: prdata = '0;
    endcase
  end

  // Shared min/max unit, one edge per cycle
  crs_edge_unit u_edge (
    .cur_edge  (cur_r[edge_idx_r]),
    .new_edge  (new_r[edge_idx_r]),
    .take_max  (!edge_idx_r[1]),
    .clip_edge (clip_edge)
  );

  // Stack memory: entry k holds the rectangle of level k
  assign wr_en   = (state_r == S_CLIP) && (edge_idx_r == 2'(EDGE_Y2));
  assign wr_addr = level_r + LVL_ONE;
  assign rd_addr = level_r - LVL_ONE;
  always_comb begin
    wr_data          = cur_r;
    wr_data[EDGE_Y2] = clip_edge;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Command sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      edge_idx_r  <= '0;
      level_r     <= '0;
      cur_r       <= {RST_Y2, RST_X2, RST_Y1, RST_X1};
      out_valid_r <= 1'b0;
      status_r    <= STS_DONE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (in_cmd)
              CMD_PUSH: begin
                if (level_r == LVL_TOP) begin
                  status_r    <= STS_FULL;
                  out_valid_r <= 1'b1;
                end else begin
                  status_r    <= STS_DONE;
                  out_valid_r <= 1'b0;
                  new_r       <= {in_rect_y2, in_rect_x2, in_rect_y1, in_rect_x1};
                  edge_idx_r  <= '0;
                  state_r     <= S_CLIP;
                end
              end
              CMD_POP: begin
                if (level_r == '0) begin
                  status_r    <= STS_EMPTY;
                  out_valid_r <= 1'b1;
                end else if (level_r == LVL_ONE) begin
                  status_r    <= STS_DONE;
                  level_r     <= '0;
                  cur_r       <= root_rect;
                  out_valid_r <= 1'b1;
                end else begin
                  // read of the level below is captured at this edge
                  status_r    <= STS_DONE;
                  out_valid_r <= 1'b0;
                  level_r     <= rd_addr;
                  state_r     <= S_LOAD;
                end
              end
              CMD_ROOT: begin
                status_r    <= STS_DONE;
                level_r     <= '0;
                cur_r       <= root_rect;
                out_valid_r <= 1'b1;
              end
              default: begin
                status_r    <= STS_DONE;
                out_valid_r <= 1'b1;
              end
            endcase
          end else begin
            out_valid_r <= 1'b0;
          end
        end
        S_CLIP: begin
          cur_r[edge_idx_r] <= clip_edge;
          edge_idx_r        <= edge_idx_r + 2'd1;
          out_valid_r       <= (edge_idx_r == 2'(EDGE_Y2));
          if (edge_idx_r == 2'(EDGE_Y2)) begin
            level_r <= wr_addr;
            state_r <= S_IDLE;
          end
        end
        S_LOAD: begin
          cur_r       <= rd_data_r;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          out_valid_r <= 1'b0;
          state_r     <= S_IDLE;
        end
      endcase
    end
  end

  // Outputs
  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_cur_x1 = cur_r[EDGE_X1];
  assign out_cur_y1 = cur_r[EDGE_Y1];
  assign out_cur_x2 = cur_r[EDGE_X2];
  assign out_cur_y2 = cur_r[EDGE_Y2];
  assign out_level  = LEVEL_W'(level_r);
  assign out_status = status_r;

  // A result is only shown once the sequencer is back to idle
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // The last clip step always completes a successful push
  a_clip_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLIP) && (edge_idx_r == 2'(EDGE_Y2)) |=>
      out_valid && (status_r == STS_DONE) && (level_r == $past(wr_addr)))
    else $error("push did not complete");

  // Pop at the root leaves the level alone and reports empty
  a_pop_root: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_cmd == CMD_POP) && (level_r == '0) |=>
      out_valid && (status_r == STS_EMPTY) && (level_r == '0))
    else $error("pop at root mishandled");

  // The stack is never written past its top entry
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (level_r != LVL_TOP))
    else $error("stack write beyond top");

endmodule

>>> design/crs_edge_unit.sv
// Shared signed min/max unit: intersects one edge per use.
module crs_edge_unit (
  input  crs_pkg::coord_t cur_edge,
  input  crs_pkg::coord_t new_edge,
  input  logic            take_max,
  output crs_pkg::coord_t clip_edge
);
  import crs_pkg::*;

  logic new_gt;

  // Low corners keep the larger edge, high corners the smaller
  assign new_gt    = (new_edge > cur_edge);
  assign clip_edge = (take_max == new_gt) && (new_edge != cur_edge) ? new_edge : cur_edge;

endmodule
